// ===== rtl/core/see_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// see_pkg: shared types and constants
// Beat structs, error codes, character codes, ALU ops, the iterative-unit request and FSM states.
// ----------------------------------------------------------------------------
package see_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         error_code;
    } out_beat_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_OTHER
    } alu_op_t;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } iter_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ1,
        ST_READ2,
        ST_ITER,
        ST_WRITE,
        ST_READTOP,
        ST_REPORT
    } state_t;

endpackage

// ===== rtl/core/see_iter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// see_iter_unit: iterative divide and power
// Restoring divide, one quotient bit a cycle; square-and-multiply, each
// exponent bit taking a multiply step then a square step.
// ----------------------------------------------------------------------------
module see_iter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  see_pkg::iter_req_t  req,
    output logic                done,
    output logic [31:0]         result
);
    import see_pkg::*;

    logic        busy_reg, busy_next;
    logic        div_reg, div_next;
    logic        phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [31:0] mag_a, mag_b;
    logic [32:0] trial;
    logic [31:0] mul_res;
    logic [31:0] mul_x, mul_y;

    assign mag_a = req.a[31] ? (32'd0 - req.a) : req.a;
    assign mag_b = req.b[31] ? (32'd0 - req.b) : req.b;
    assign mul_x = phase_reg ? y_reg : acc_reg;
    assign mul_y = y_reg;
    assign mul_res = mul_x * mul_y;
    assign trial = {rem_reg, x_reg[31]};

    always_comb
    begin
        busy_next  = busy_reg;
        div_next   = div_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            busy_next  = 1'b1;
            div_next   = req.is_div;
            phase_next = 1'b0;
            cnt_next   = 6'd0;
            rem_next   = 32'd0;
            acc_next   = 32'd1;
            neg_next   = req.a[31] ^ req.b[31];
            if (req.is_div)
            begin
                x_next = mag_a;
                y_next = mag_b;
            end
            else
            begin
                x_next = req.b;
                y_next = req.a;
                if (req.b[31])
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (req.a == 32'd1)
                        acc_next = 32'd1;
                    else if (req.a == 32'hFFFF_FFFF)
                        acc_next = req.b[0] ? 32'hFFFF_FFFF : 32'd1;
                    else
                        acc_next = 32'd0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                x_next = {x_reg[30:0], 1'b0};
                if (trial >= {1'b0, y_reg})
                begin
                    rem_next = trial[31:0] - y_reg;
                    acc_next = {acc_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    acc_next = {acc_reg[30:0], 1'b0};
                end
                if (cnt_reg == 6'd0)
                    acc_next = {31'd0, trial >= {1'b0, y_reg}};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (neg_reg)
                        acc_next = 32'd0 - acc_next;
                end
            end
            else if (x_reg == 32'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!phase_reg)
            begin
                if (x_reg[0])
                    acc_next = mul_res;
                phase_next = 1'b1;
            end
            else
            begin
                y_next     = mul_res;
                x_next     = {1'b0, x_reg[31:1]};
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/core/see_stack_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// see_stack_mem: operand stack storage
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module see_stack_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/stack_expression_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_expression_evaluator: postfix/prefix integer expression evaluator
// One character per input beat; one result beat per expression.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry {char_code, is_last}. Digits push 0..9, other
//   characters pop two operands and push the result of ^ * / + - (else 0).
//   notation_mode (cfg_we/cfg_data) picks postfix (0) or reversed prefix (1).
//   On a beat with is_last set, out_valid/out_ready carry the top of stack
//   (0 if empty) and the first error since the last report; stack clears.
// Sequence (one item at a time, state in a single-port stack RAM):
//   digit: IDLE, WRITE, READTOP; operator on a short stack: IDLE, READTOP;
//   + - * and others: IDLE, READ1, READ2, WRITE, READTOP; power and divide
//   (nonzero divisor) wait in ITER after READ2; a last character adds REPORT.
// Stall: the result waits in an output register; the next expression's
//   characters are taken while it waits, and only the next report stalls.
// Reset: stack empty, error clear, postfix mode. No clearing pass.
// ----------------------------------------------------------------------------
module stack_expression_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  see_pkg::in_beat_t      in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output see_pkg::out_beat_t     out_data
);
    import see_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t         state_reg, state_next;
    logic           mode_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     err_reg, err_next;
    logic [7:0]     ch_reg, ch_next;
    logic           last_reg, last_next;
    logic [31:0]    first_reg, first_next;
    logic [31:0]    res_reg, res_next;
    logic           out_valid_reg, out_valid_next;
    out_beat_t      out_reg, out_next;

    logic           we;
    logic [AW-1:0]  addr;
    logic [31:0]    wdata, rdata;
    iter_req_t      ireq;
    logic           idone;
    logic [31:0]    ires;
    logic [31:0]    op_a, op_b;
    alu_op_t        aop;

    see_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

    see_iter_unit u_iter (
        .clk(clk), .rst_n(rst_n), .req(ireq), .done(idone), .result(ires));

    assign op_a = mode_reg ? first_reg : rdata;
    assign op_b = mode_reg ? rdata : first_reg;

    always_comb
    begin
        case (ch_reg)
            CH_ADD:  aop = ALU_ADD;
            CH_SUB:  aop = ALU_SUB;
            CH_MUL:  aop = ALU_MUL;
            default: aop = ALU_OTHER;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        we             = 1'b0;
        addr           = cnt_reg[AW-1:0];
        wdata          = res_reg;
        ireq           = '0;
        in_ready       = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next   = in_data.char_code;
                    last_next = in_data.is_last;
                    if (in_data.char_code inside {[CH_ZERO:CH_NINE]})
                    begin
                        res_next   = {24'd0, in_data.char_code - CH_ZERO};
                        state_next = ST_WRITE;
                    end
                    else if (cnt_reg < CW'(2))
                    begin
                        if (err_reg == ERR_NONE)
                            err_next = ERR_UNDERFLOW;
                        state_next = ST_READTOP;
                    end
                    else
                    begin
                        addr       = AW'(cnt_reg - CW'(1));
                        cnt_next   = cnt_reg - CW'(2);
                        state_next = ST_READ1;
                    end
                end
            end
            ST_READ1:
            begin
                addr       = AW'(cnt_reg);
                first_next = rdata;
                state_next = ST_READ2;
            end
            ST_READ2:
            begin
                state_next = ST_WRITE;
                case (aop)
                    ALU_ADD: res_next = op_a + op_b;
                    ALU_SUB: res_next = op_a - op_b;
                    ALU_MUL: res_next = op_a * op_b;
                    default: res_next = 32'd0;
                endcase
                if (ch_reg == CH_DIV && op_b == 32'd0)
                begin
                    res_next = 32'd0;
                    if (err_reg == ERR_NONE)
                        err_next = ERR_DIVZERO;
                end
                else if (ch_reg == CH_DIV || ch_reg == CH_POW)
                begin
                    ireq.start  = 1'b1;
                    ireq.is_div = (ch_reg == CH_DIV);
                    ireq.a      = op_a;
                    ireq.b      = op_b;
                    state_next  = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (idone)
                begin
                    res_next   = ires;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                begin
                    if (err_reg == ERR_NONE)
                        err_next = ERR_OVERFLOW;
                end
                else
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                state_next = ST_READTOP;
            end
            ST_READTOP:
            begin
                addr = AW'(cnt_reg - CW'(1));
                state_next = last_reg ? ST_REPORT : ST_IDLE;
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.result_value = (cnt_reg != '0) ? rdata : 32'sd0;
                    out_next.error_code   = err_reg;
                    cnt_next              = '0;
                    err_next              = ERR_NONE;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    addr = AW'(cnt_reg - CW'(1));
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            cnt_reg       <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/see_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// see_checker: port-level checks
// Handshake stability and reporting discipline, bound to the top level.
// ----------------------------------------------------------------------------
module see_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input see_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input see_pkg::out_beat_t out_data
);
    import see_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed under stall");

    a_out_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_data.is_last, 3)
            || $past(in_valid && in_ready && in_data.is_last, 4)
            || $past(in_valid && in_ready && in_data.is_last, 5)
            || !$past(in_ready))
        else $error("result without a last character");

    a_no_take_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two characters accepted back to back");

endmodule

bind stack_expression_evaluator see_checker u_see_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
